// File: rtl/ubfp_pkg.sv
`timescale 1ns / 1ps
// Types, codes and constants shared by the bootloader flash programmer.
package ubfp_pkg;

  localparam int MAX_CHUNK_DEFAULT = 256;
  localparam int MAX_RES = 5;
  localparam int RES_CNT_W = 3;

  localparam logic [31:0] START_ADDRESS_RESET = 32'h0800_0000;
  localparam logic [2:0] RETRY_LIMIT_RESET = 3'd3;
  localparam logic [2:0] RETRY_SATURATE = 3'd7;

  localparam logic CFG_START_ADDRESS = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  localparam logic [7:0] B_SYNC = 8'h7F;
  localparam logic [7:0] B_ACK = 8'h79;
  localparam logic [7:0] B_NACK = 8'h1F;
  localparam logic [7:0] B_RD_CMD = 8'h11;
  localparam logic [7:0] B_ER_CMD = 8'h43;
  localparam logic [7:0] B_WR_CMD = 8'h31;
  localparam logic [7:0] B_ER_ALL_HI = 8'hFF;
  localparam logic [7:0] B_ER_ALL_LO = 8'h00;
  localparam logic [7:0] B_OPT_LEN = 8'h01;

  localparam logic [7:0] OPT_ADDR [5] = '{8'h1F, 8'hFF, 8'hF8, 8'h00, 8'h18};

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_SYNC = 3'd1,
    ERR_PROTECT = 3'd2,
    ERR_ERASE = 3'd3,
    ERR_WRITE = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_REPLY = 3'd1,
    KIND_TIMEOUT = 3'd2,
    KIND_CHUNK = 3'd3,
    KIND_DATA = 3'd4,
    KIND_FINISH = 3'd5,
    KIND_ABORT = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SYNC,
    PH_RP_CMD,
    PH_RP_ADDR,
    PH_RP_LEN,
    PH_ER_CMD,
    PH_ER_ARG,
    PH_READY,
    PH_WR_CMD,
    PH_WR_ADDR,
    PH_WR_DATA,
    PH_WR_ACK,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic [2:0] retry_count;
    logic [31:0] write_address;
    logic [7:0] running_checksum;
    logic [8:0] current_length;
    logic [8:0] bytes_remaining;
    logic boot_sel;
  } ubfp_state_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic done_res;
    logic ready_for_chunk;
    logic reset_level;
    logic boot_level;
    logic [7:0] tx_value;
    logic tx_valid;
  } result_t;

  typedef result_t [MAX_RES-1:0] res_batch_t;

  function automatic result_t mk_tx(logic [7:0] val, logic boot, logic rdy);
    result_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_value = val;
    r.boot_level = boot;
    r.reset_level = 1'b1;
    r.ready_for_chunk = rdy;
    return r;
  endfunction

  function automatic result_t mk_pin(logic rst_lvl, logic done, err_t err, logic boot,
                                     logic rdy);
    result_t r;
    r = '0;
    r.boot_level = boot;
    r.reset_level = rst_lvl;
    r.ready_for_chunk = rdy;
    r.done_res = done;
    r.error_code = err;
    return r;
  endfunction

  function automatic err_t phase_code(phase_t ph);
    err_t e;
    case (ph)
      PH_SYNC: e = ERR_SYNC;
      PH_RP_CMD, PH_RP_ADDR, PH_RP_LEN: e = ERR_PROTECT;
      PH_ER_CMD, PH_ER_ARG: e = ERR_ERASE;
      PH_WR_CMD, PH_WR_ADDR, PH_WR_DATA, PH_WR_ACK: e = ERR_WRITE;
      default: e = ERR_NONE;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/ubfp_step.sv
`timescale 1ns / 1ps
// Session step logic: next state and the burst of result beats for one item.
module ubfp_step import ubfp_pkg::*; #(
  parameter int MAX_CHUNK = MAX_CHUNK_DEFAULT
) (
  input  ubfp_state_t st,
  input  logic [2:0] kind,
  input  logic [7:0] reply_byte,
  input  logic [8:0] chunk_length,
  input  logic [7:0] data_value,
  input  logic [31:0] start_address,
  input  logic [2:0] sync_retry_limit,
  output ubfp_state_t nxt,
  output res_batch_t res,
  output logic [RES_CNT_W-1:0] res_cnt
);

  logic is_reply;
  logic is_ack;
  logic is_nack;
  logic [7:0] a0, a1, a2, a3;
  logic [7:0] lm1;
  logic [8:0] rem_next;
  logic [7:0] csum_next;

  assign is_reply = (kind == KIND_REPLY);
  assign is_ack = is_reply && (reply_byte == B_ACK);
  assign is_nack = is_reply && (reply_byte == B_NACK);
  assign a0 = st.write_address[31:24];
  assign a1 = st.write_address[23:16];
  assign a2 = st.write_address[15:8];
  assign a3 = st.write_address[7:0];
  assign lm1 = 8'(st.current_length - 9'd1);
  assign rem_next = st.bytes_remaining - 9'd1;
  assign csum_next = st.running_checksum ^ data_value;

  always_comb begin
    nxt = st;
    res = '0;
    res_cnt = '0;
    case (kind)
      KIND_START: begin
        if (st.phase == PH_IDLE || st.phase == PH_DONE) begin
          nxt.phase = PH_SYNC;
          nxt.retry_count = '0;
          nxt.write_address = start_address;
          nxt.running_checksum = '0;
          nxt.current_length = '0;
          nxt.bytes_remaining = '0;
          nxt.boot_sel = 1'b1;
          res[0] = mk_pin(1'b0, 1'b0, ERR_NONE, 1'b1, 1'b0);
          res[1] = mk_tx(B_SYNC, 1'b1, 1'b0);
          res_cnt = 3'd2;
        end
      end
      KIND_ABORT: begin
        if (st.phase != PH_IDLE && st.phase != PH_DONE) begin
          nxt.boot_sel = 1'b0;
          nxt.phase = PH_DONE;
          res[0] = mk_pin(1'b0, 1'b0, ERR_NONE, 1'b0, st.phase == PH_READY);
          res[1] = mk_pin(1'b1, 1'b1, phase_code(st.phase), 1'b0, 1'b0);
          res_cnt = 3'd2;
        end
      end
      KIND_FINISH: begin
        if (st.phase == PH_READY) begin
          nxt.boot_sel = 1'b0;
          nxt.phase = PH_DONE;
          res[0] = mk_pin(1'b0, 1'b0, ERR_NONE, 1'b0, 1'b0);
          res[1] = mk_pin(1'b1, 1'b1, ERR_NONE, 1'b0, 1'b0);
          res_cnt = 3'd2;
        end
      end
      KIND_CHUNK: begin
        if (st.phase == PH_READY && chunk_length != '0) begin
          nxt.current_length = (chunk_length > 9'(MAX_CHUNK)) ? 9'(MAX_CHUNK) : chunk_length;
          nxt.phase = PH_WR_CMD;
          res[0] = mk_tx(B_WR_CMD, st.boot_sel, 1'b0);
          res[1] = mk_tx(~B_WR_CMD, st.boot_sel, 1'b0);
          res_cnt = 3'd2;
        end
      end
      KIND_DATA: begin
        if (st.phase == PH_WR_DATA && st.bytes_remaining != '0) begin
          nxt.running_checksum = csum_next;
          nxt.bytes_remaining = rem_next;
          res[0] = mk_tx(data_value, st.boot_sel, 1'b0);
          res_cnt = 3'd1;
          if (rem_next == '0) begin
            nxt.phase = PH_WR_ACK;
            res[1] = mk_tx(csum_next, st.boot_sel, 1'b0);
            res_cnt = 3'd2;
          end
        end
      end
      KIND_REPLY, KIND_TIMEOUT: begin
        case (st.phase)
          PH_SYNC: begin
            if (!is_reply) begin
              res[0] = mk_tx(B_SYNC, st.boot_sel, 1'b0);
              res_cnt = 3'd1;
            end else if (is_ack) begin
              nxt.phase = PH_RP_CMD;
              res[0] = mk_tx(B_RD_CMD, st.boot_sel, 1'b0);
              res[1] = mk_tx(~B_RD_CMD, st.boot_sel, 1'b0);
              res_cnt = 3'd2;
            end else if (is_nack && st.retry_count <= sync_retry_limit) begin
              if (st.retry_count != RETRY_SATURATE) begin
                nxt.retry_count = st.retry_count + 3'd1;
              end
              res[0] = mk_pin(1'b0, 1'b0, ERR_NONE, st.boot_sel, 1'b0);
              res[1] = mk_tx(B_SYNC, st.boot_sel, 1'b0);
              res_cnt = 3'd2;
            end else begin
              nxt.phase = PH_DONE;
              res[0] = mk_pin(1'b1, 1'b1, ERR_SYNC, st.boot_sel, 1'b0);
              res_cnt = 3'd1;
            end
          end
          PH_RP_CMD: begin
            if (is_ack) begin
              nxt.phase = PH_RP_ADDR;
              for (int i = 0; i < 5; i++) begin
                res[i] = mk_tx(OPT_ADDR[i], st.boot_sel, 1'b0);
              end
              res_cnt = 3'd5;
            end else if (is_nack) begin
              nxt.phase = PH_ER_CMD;
              res[0] = mk_tx(B_ER_CMD, st.boot_sel, 1'b0);
              res[1] = mk_tx(~B_ER_CMD, st.boot_sel, 1'b0);
              res_cnt = 3'd2;
            end else begin
              nxt.phase = PH_DONE;
              res[0] = mk_pin(1'b1, 1'b1, ERR_PROTECT, st.boot_sel, 1'b0);
              res_cnt = 3'd1;
            end
          end
          PH_RP_ADDR: begin
            if (is_ack) begin
              nxt.phase = PH_RP_LEN;
              res[0] = mk_tx(B_OPT_LEN, st.boot_sel, 1'b0);
              res[1] = mk_tx(~B_OPT_LEN, st.boot_sel, 1'b0);
              res_cnt = 3'd2;
            end else begin
              nxt.phase = PH_DONE;
              res[0] = mk_pin(1'b1, 1'b1, ERR_PROTECT, st.boot_sel, 1'b0);
              res_cnt = 3'd1;
            end
          end
          PH_RP_LEN: begin
            if (is_reply) begin
              nxt.phase = PH_ER_CMD;
              res[0] = mk_tx(B_ER_CMD, st.boot_sel, 1'b0);
              res[1] = mk_tx(~B_ER_CMD, st.boot_sel, 1'b0);
              res_cnt = 3'd2;
            end else begin
              nxt.phase = PH_DONE;
              res[0] = mk_pin(1'b1, 1'b1, ERR_PROTECT, st.boot_sel, 1'b0);
              res_cnt = 3'd1;
            end
          end
          PH_ER_CMD: begin
            if (is_ack) begin
              nxt.phase = PH_ER_ARG;
              res[0] = mk_tx(B_ER_ALL_HI, st.boot_sel, 1'b0);
              res[1] = mk_tx(B_ER_ALL_LO, st.boot_sel, 1'b0);
              res_cnt = 3'd2;
            end else begin
              nxt.phase = PH_DONE;
              res[0] = mk_pin(1'b1, 1'b1, ERR_ERASE, st.boot_sel, 1'b0);
              res_cnt = 3'd1;
            end
          end
          PH_ER_ARG: begin
            if (is_ack) begin
              nxt.phase = PH_READY;
              res[0] = mk_pin(1'b1, 1'b0, ERR_NONE, st.boot_sel, 1'b1);
            end else begin
              nxt.phase = PH_DONE;
              res[0] = mk_pin(1'b1, 1'b1, ERR_ERASE, st.boot_sel, 1'b0);
            end
            res_cnt = 3'd1;
          end
          PH_WR_CMD: begin
            if (is_ack) begin
              nxt.phase = PH_WR_ADDR;
              res[0] = mk_tx(a0, st.boot_sel, 1'b0);
              res[1] = mk_tx(a1, st.boot_sel, 1'b0);
              res[2] = mk_tx(a2, st.boot_sel, 1'b0);
              res[3] = mk_tx(a3, st.boot_sel, 1'b0);
              res[4] = mk_tx(a0 ^ a1 ^ a2 ^ a3, st.boot_sel, 1'b0);
              res_cnt = 3'd5;
            end else begin
              nxt.phase = PH_DONE;
              res[0] = mk_pin(1'b1, 1'b1, ERR_WRITE, st.boot_sel, 1'b0);
              res_cnt = 3'd1;
            end
          end
          PH_WR_ADDR: begin
            if (is_ack) begin
              nxt.phase = PH_WR_DATA;
              nxt.running_checksum = lm1;
              nxt.bytes_remaining = st.current_length;
              res[0] = mk_tx(lm1, st.boot_sel, 1'b0);
            end else begin
              nxt.phase = PH_DONE;
              res[0] = mk_pin(1'b1, 1'b1, ERR_WRITE, st.boot_sel, 1'b0);
            end
            res_cnt = 3'd1;
          end
          PH_WR_ACK: begin
            if (is_ack) begin
              nxt.write_address = st.write_address + 32'(st.current_length);
              nxt.phase = PH_READY;
              res[0] = mk_pin(1'b1, 1'b0, ERR_NONE, st.boot_sel, 1'b1);
            end else begin
              nxt.phase = PH_DONE;
              res[0] = mk_pin(1'b1, 1'b1, ERR_WRITE, st.boot_sel, 1'b0);
            end
            res_cnt = 3'd1;
          end
          default: begin
            res_cnt = '0;
          end
        endcase
      end
      default: begin
        res_cnt = '0;
      end
    endcase
  end

endmodule

// File: rtl/uart_bootloader_flash_programmer.sv
`timescale 1ns / 1ps
// Top level: host-side UART bootloader sequencer that programs target flash.
//
// Events enter on the s_ channel: s_tuser carries the event kind (start, reply
// byte, reply timeout, chunk begin, data byte, finish, abort) and s_tdata the
// reply byte, chunk length and data byte. Each event yields zero to five
// result beats on the m_ channel; each beat holds a byte to send to the target
// (when tx_valid is set) and the levels for the boot and reset pins, plus
// chunk-ready, done and error status. m_tlast marks the final beat of an event.
// An accepted event is held in an input register and is judged once the result
// buffer is empty or hands out the final beat of its burst; the whole new burst
// is then loaded into the result buffer, which shows its first beat. The buffer
// hands out one beat per cycle while m_tready is high, and the input register
// takes the next event while a burst still drains.
// When the receiver stalls, the burst holds and the input stage fills and then
// drops s_tready. Configuration writes are taken at any edge with cfg_we set.
// Reset returns the session to idle, empties both stages and reloads the
// default start address and sync retry limit.
module uart_bootloader_flash_programmer import ubfp_pkg::*; #(
  parameter int MAX_CHUNK = MAX_CHUNK_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [31:0] s_tdata,  // reply_byte[7:0], chunk_length[16:8], data_value[24:17]
  input  logic [2:0] s_tuser,   // kind[2:0]
  output logic m_tvalid,
  input  logic m_tready,
  output logic [15:0] m_tdata,  // tx_valid[0], tx_value[8:1], boot_level[9],
                                // reset_level[10], ready_for_chunk[11],
                                // done_res[12], error_code[15:13]
  output logic m_tlast,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] start_address;
  logic [2:0] sync_retry_limit;

  logic in_valid;
  logic [2:0] in_kind;
  logic [7:0] in_reply_byte;
  logic [8:0] in_chunk_length;
  logic [7:0] in_data_value;

  ubfp_state_t st;
  ubfp_state_t st_next;
  res_batch_t step_res;
  logic [RES_CNT_W-1:0] step_cnt;

  logic bat_valid;
  res_batch_t bat;
  logic [RES_CNT_W-1:0] bat_cnt;
  logic [RES_CNT_W-1:0] bat_idx;

  logic bat_last;
  logic drain_last;
  logic consume;

  ubfp_step #(
    .MAX_CHUNK(MAX_CHUNK)
  ) u_step (
    .st(st),
    .kind(in_kind),
    .reply_byte(in_reply_byte),
    .chunk_length(in_chunk_length),
    .data_value(in_data_value),
    .start_address(start_address),
    .sync_retry_limit(sync_retry_limit),
    .nxt(st_next),
    .res(step_res),
    .res_cnt(step_cnt)
  );

  assign bat_last = (bat_idx == bat_cnt - 3'd1);
  assign drain_last = bat_valid && m_tready && bat_last;
  assign consume = in_valid && (!bat_valid || drain_last);
  assign s_tready = !in_valid || consume;

  assign m_tvalid = bat_valid;
  assign m_tdata = bat[bat_idx];
  assign m_tlast = bat_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= START_ADDRESS_RESET;
      sync_retry_limit <= RETRY_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_ADDRESS: start_address <= cfg_data;
        CFG_RETRY_LIMIT: sync_retry_limit <= cfg_data[2:0];
        default: start_address <= start_address;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_reply_byte <= s_tdata[7:0];
      in_chunk_length <= s_tdata[16:8];
      in_data_value <= s_tdata[24:17];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, default: '0};
    end else if (consume) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bat_valid <= 1'b0;
      bat_cnt <= '0;
      bat_idx <= '0;
    end else if (consume) begin
      bat_valid <= (step_cnt != '0);
      bat_cnt <= step_cnt;
      bat_idx <= '0;
    end else if (drain_last) begin
      bat_valid <= 1'b0;
    end else if (bat_valid && m_tready) begin
      bat_idx <= bat_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      bat <= step_res;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst) bat_valid |-> (bat_cnt != '0))
    else $error("result buffer valid with an empty burst");

  assert property (@(posedge clk) disable iff (rst) bat_valid |-> (bat_idx < bat_cnt))
    else $error("result index past the end of the burst");

  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tdata[12]) |-> m_tlast)
    else $error("session end beat is not the final beat of its event");

  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> (!m_tvalid && s_tready))
    else $error("pipeline not empty after reset");
`endif

endmodule

// File: tb/uart_bootloader_flash_programmer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bootloader flash programmer, with a scoreboard predictor.
module uart_bootloader_flash_programmer_tb;
  import ubfp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 150;

  class bootloader_scoreboard;
    typedef struct packed {
      result_t beat;
      logic last;
    } tx_beat_t;

    logic [31:0] start_addr;
    logic [2:0] retry_limit;
    phase_t phase;
    logic [2:0] retry_cnt;
    logic [31:0] wr_addr;
    logic [7:0] csum;
    logic [8:0] cur_len;
    logic [8:0] remaining;
    logic boot;
    tx_beat_t pending_beats[$];
    int unsigned faults;

    function new();
      start_addr = START_ADDRESS_RESET;
      retry_limit = RETRY_LIMIT_RESET;
      phase = PH_IDLE;
      retry_cnt = '0;
      wr_addr = '0;
      csum = '0;
      cur_len = '0;
      remaining = '0;
      boot = 1'b0;
      faults = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == CFG_START_ADDRESS) begin
        start_addr = value;
      end else begin
        retry_limit = value[2:0];
      end
    endfunction

    function void push_beat(logic valid, logic [7:0] val, logic rst_lvl, logic done, err_t err);
      tx_beat_t b;
      b = '0;
      b.beat.tx_valid = valid;
      b.beat.tx_value = valid ? val : 8'h00;
      b.beat.boot_level = boot;
      b.beat.reset_level = rst_lvl;
      b.beat.ready_for_chunk = (phase == PH_READY);
      b.beat.done_res = done;
      b.beat.error_code = err;
      pending_beats.push_back(b);
    endfunction

    function void send_byte(logic [7:0] v);
      push_beat(1'b1, v, 1'b1, 1'b0, ERR_NONE);
    endfunction

    function void end_session(err_t code);
      phase = PH_DONE;
      push_beat(1'b0, 8'h00, 1'b1, 1'b1, code);
    endfunction

    // Advances the session by one accepted event and queues the beats it causes.
    function int take_event(logic [2:0] kind, logic [7:0] rb, logic [8:0] clen, logic [7:0] dv);
      int base_size;
      tx_beat_t tail;
      logic is_reply;
      logic is_ack;
      logic [7:0] len_m1;
      err_t code;
      base_size = pending_beats.size();
      is_reply = (kind == KIND_REPLY);
      is_ack = is_reply && (rb == B_ACK);
      case (kind)
        KIND_START: begin
          if (phase == PH_IDLE || phase == PH_DONE) begin
            phase = PH_SYNC;
            retry_cnt = '0;
            wr_addr = start_addr;
            csum = '0;
            cur_len = '0;
            remaining = '0;
            boot = 1'b1;
            push_beat(1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
            send_byte(B_SYNC);
          end
        end
        KIND_ABORT: begin
          if (phase != PH_IDLE && phase != PH_DONE) begin
            case (phase)
              PH_SYNC: code = ERR_SYNC;
              PH_RP_CMD, PH_RP_ADDR, PH_RP_LEN: code = ERR_PROTECT;
              PH_ER_CMD, PH_ER_ARG: code = ERR_ERASE;
              PH_WR_CMD, PH_WR_ADDR, PH_WR_DATA, PH_WR_ACK: code = ERR_WRITE;
              default: code = ERR_NONE;
            endcase
            boot = 1'b0;
            push_beat(1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
            end_session(code);
          end
        end
        KIND_FINISH: begin
          if (phase == PH_READY) begin
            boot = 1'b0;
            phase = PH_DONE;
            push_beat(1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
            push_beat(1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE);
          end
        end
        KIND_CHUNK: begin
          if (phase == PH_READY && clen != 9'd0) begin
            cur_len = (clen > MAX_CHUNK_DEFAULT) ? 9'(MAX_CHUNK_DEFAULT) : clen;
            phase = PH_WR_CMD;
            send_byte(B_WR_CMD);
            send_byte(~B_WR_CMD);
          end
        end
        KIND_DATA: begin
          if (phase == PH_WR_DATA && remaining != 9'd0) begin
            send_byte(dv);
            csum = csum ^ dv;
            remaining = remaining - 9'd1;
            if (remaining == 9'd0) begin
              phase = PH_WR_ACK;
              send_byte(csum);
            end
          end
        end
        KIND_REPLY, KIND_TIMEOUT: begin
          case (phase)
            PH_SYNC: begin
              if (!is_reply) begin
                send_byte(B_SYNC);
              end else if (rb == B_ACK) begin
                phase = PH_RP_CMD;
                send_byte(B_RD_CMD);
                send_byte(~B_RD_CMD);
              end else if (rb == B_NACK) begin
                if (retry_cnt > retry_limit) begin
                  end_session(ERR_SYNC);
                end else begin
                  push_beat(1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
                  send_byte(B_SYNC);
                  if (retry_cnt < RETRY_SATURATE) retry_cnt = retry_cnt + 3'd1;
                end
              end else begin
                end_session(ERR_SYNC);
              end
            end
            PH_RP_CMD: begin
              if (is_ack) begin
                phase = PH_RP_ADDR;
                for (int i = 0; i < 5; i++) send_byte(OPT_ADDR[i]);
              end else if (is_reply && rb == B_NACK) begin
                phase = PH_ER_CMD;
                send_byte(B_ER_CMD);
                send_byte(~B_ER_CMD);
              end else begin
                end_session(ERR_PROTECT);
              end
            end
            PH_RP_ADDR: begin
              if (is_ack) begin
                phase = PH_RP_LEN;
                send_byte(B_OPT_LEN);
                send_byte(~B_OPT_LEN);
              end else begin
                end_session(ERR_PROTECT);
              end
            end
            PH_RP_LEN: begin
              if (is_reply) begin
                phase = PH_ER_CMD;
                send_byte(B_ER_CMD);
                send_byte(~B_ER_CMD);
              end else begin
                end_session(ERR_PROTECT);
              end
            end
            PH_ER_CMD: begin
              if (is_ack) begin
                phase = PH_ER_ARG;
                send_byte(B_ER_ALL_HI);
                send_byte(B_ER_ALL_LO);
              end else begin
                end_session(ERR_ERASE);
              end
            end
            PH_ER_ARG: begin
              if (is_ack) begin
                phase = PH_READY;
                push_beat(1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE);
              end else begin
                end_session(ERR_ERASE);
              end
            end
            PH_WR_CMD: begin
              if (is_ack) begin
                phase = PH_WR_ADDR;
                send_byte(wr_addr[31:24]);
                send_byte(wr_addr[23:16]);
                send_byte(wr_addr[15:8]);
                send_byte(wr_addr[7:0]);
                send_byte(wr_addr[31:24] ^ wr_addr[23:16] ^ wr_addr[15:8] ^ wr_addr[7:0]);
              end else begin
                end_session(ERR_WRITE);
              end
            end
            PH_WR_ADDR: begin
              if (is_ack) begin
                len_m1 = 8'(cur_len - 9'd1);
                phase = PH_WR_DATA;
                csum = len_m1;
                remaining = cur_len;
                send_byte(len_m1);
              end else begin
                end_session(ERR_WRITE);
              end
            end
            PH_WR_ACK: begin
              if (is_ack) begin
                wr_addr = wr_addr + {23'd0, cur_len};
                phase = PH_READY;
                push_beat(1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE);
              end else begin
                end_session(ERR_WRITE);
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
      if (pending_beats.size() > base_size) begin
        tail = pending_beats.pop_back();
        tail.last = 1'b1;
        pending_beats.push_back(tail);
      end
      return pending_beats.size() - base_size;
    endfunction

    function void note_fault(string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
    endfunction

    function void check_beat(logic [15:0] data, logic lastbit);
      result_t got;
      tx_beat_t want;
      got = result_t'(data);
      if (pending_beats.size() == 0) begin
        note_fault($sformatf("unexpected beat: data=%h last=%b", data, lastbit));
        return;
      end
      want = pending_beats.pop_front();
      if (got.tx_valid !== want.beat.tx_valid || got.tx_value !== want.beat.tx_value ||
          got.boot_level !== want.beat.boot_level ||
          got.reset_level !== want.beat.reset_level ||
          got.ready_for_chunk !== want.beat.ready_for_chunk ||
          got.done_res !== want.beat.done_res || got.error_code !== want.beat.error_code ||
          lastbit !== want.last) begin
        note_fault({$sformatf(
          "beat mismatch: expected valid=%b byte=%h boot=%b rst=%b rdy=%b done=%b err=%0d last=%b",
          want.beat.tx_valid, want.beat.tx_value, want.beat.boot_level,
          want.beat.reset_level, want.beat.ready_for_chunk, want.beat.done_res,
          want.beat.error_code, want.last), "\n", $sformatf(
          "              actual   valid=%b byte=%h boot=%b rst=%b rdy=%b done=%b err=%0d last=%b",
          got.tx_valid, got.tx_value, got.boot_level, got.reset_level,
          got.ready_for_chunk, got.done_res, got.error_code, lastbit)});
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  bootloader_scoreboard sb = new();
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  uart_bootloader_flash_programmer i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      stall_left <= LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("uart_bootloader_flash_programmer_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic write_regs(input logic [31:0] addr, input logic [2:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_ADDRESS;
    cfg_data <= addr;
    @(posedge clk);
    sb.set_reg(CFG_START_ADDRESS, addr);
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_data <= {29'd0, limit};
    @(posedge clk);
    sb.set_reg(CFG_RETRY_LIMIT, {29'd0, limit});
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic [2:0] kind, input logic [7:0] rb, input logic [8:0] clen,
                           input logic [7:0] dv, output int nbeats);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {7'd0, dv, clen, rb};
    do @(posedge clk); while (!s_tready);
    nbeats = sb.take_event(kind, rb, clen, dv);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly the reply the session is waiting for, with some failures and noise mixed in.
  task automatic pick_item(output logic [2:0] kind, output logic [7:0] rb,
                           output logic [8:0] clen, output logic [7:0] dv);
    int roll;
    roll = $urandom_range(0, 99);
    rb = 8'($urandom_range(0, 255));
    clen = 9'($urandom_range(0, 511));
    dv = 8'($urandom_range(0, 255));
    kind = KIND_REPLY;
    case (sb.phase)
      PH_IDLE, PH_DONE: begin
        if (roll < 85) kind = KIND_START;
        else kind = 3'($urandom_range(1, 7));
      end
      PH_SYNC: begin
        if (roll < 60) rb = B_ACK;
        else if (roll < 80) rb = B_NACK;
        else if (roll < 92) kind = KIND_TIMEOUT;
      end
      PH_RP_CMD: begin
        if (roll < 70) rb = B_ACK;
        else if (roll < 88) rb = B_NACK;
        else if (roll < 94) kind = KIND_TIMEOUT;
      end
      PH_RP_LEN: begin
        if (roll >= 90) kind = KIND_TIMEOUT;
      end
      PH_READY: begin
        if (roll < 3) begin
          kind = KIND_CHUNK;
          clen = 9'd0;
        end else if (roll < 6) begin
          kind = KIND_CHUNK;
          clen = 9'($urandom_range(256, 511));
        end else if (roll < 75) begin
          kind = KIND_CHUNK;
          clen = 9'($urandom_range(1, 12));
        end else if (roll < 87) begin
          kind = KIND_FINISH;
        end else if (roll < 91) begin
          kind = KIND_ABORT;
        end else begin
          kind = 3'($urandom_range(0, 7));
        end
      end
      PH_WR_DATA: begin
        if (roll < 95) kind = KIND_DATA;
        else if (roll < 97) kind = KIND_ABORT;
        else kind = 3'($urandom_range(0, 7));
      end
      default: begin
        if (roll < 92) rb = B_ACK;
        else if (roll < 95) rb = B_NACK;
        else if (roll < 97) kind = KIND_TIMEOUT;
        else if (roll < 98) kind = KIND_ABORT;
      end
    endcase
  endtask

  task automatic run_phase(input logic [31:0] addr, input logic [2:0] limit, input int target);
    int count;
    int nb;
    logic [2:0] kind;
    logic [7:0] rb;
    logic [8:0] clen;
    logic [7:0] dv;
    count = 0;
    write_regs(addr, limit);
    while (count < target) begin
      pick_item(kind, rb, clen, dv);
      send_item(kind, rb, clen, dv, nb);
      if (nb > 0) count++;
    end
    if (sb.phase == PH_READY) begin
      send_item(KIND_FINISH, 8'h00, 9'd0, 8'h00, nb);
    end else if (sb.phase != PH_IDLE && sb.phase != PH_DONE) begin
      send_item(KIND_ABORT, 8'h00, 9'd0, 8'h00, nb);
    end
    wait_drain();
  endtask

  initial begin
    int nb;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_regs(32'hFFFF_FFFE, 3'd0);

    send_item(KIND_DATA, 8'h00, 9'd0, 8'hA5, nb);
    send_item(3'd7, 8'hFF, 9'd511, 8'hFF, nb);
    send_item(KIND_ABORT, 8'h00, 9'd0, 8'h00, nb);
    send_item(KIND_START, 8'h00, 9'd0, 8'h00, nb);
    send_item(KIND_START, 8'h00, 9'd0, 8'h00, nb);
    send_item(KIND_TIMEOUT, 8'h00, 9'd0, 8'h00, nb);
    send_item(KIND_REPLY, B_NACK, 9'd0, 8'h00, nb);
    send_item(KIND_REPLY, B_ACK, 9'd0, 8'h00, nb);
    send_item(KIND_REPLY, B_NACK, 9'd0, 8'h00, nb);
    send_item(KIND_REPLY, B_ACK, 9'd0, 8'h00, nb);
    send_item(KIND_REPLY, B_ACK, 9'd0, 8'h00, nb);
    send_item(KIND_CHUNK, 8'h00, 9'd0, 8'h00, nb);
    send_item(KIND_DATA, 8'h00, 9'd0, 8'h5A, nb);
    send_item(KIND_CHUNK, 8'h00, 9'd1, 8'h00, nb);
    send_item(KIND_REPLY, B_ACK, 9'd0, 8'h00, nb);
    send_item(KIND_REPLY, B_ACK, 9'd0, 8'h00, nb);
    send_item(KIND_DATA, 8'h00, 9'd0, 8'hFF, nb);
    send_item(KIND_REPLY, B_ACK, 9'd0, 8'h00, nb);
    send_item(KIND_CHUNK, 8'h00, 9'd511, 8'h00, nb);
    send_item(KIND_REPLY, B_ACK, 9'd0, 8'h00, nb);
    send_item(KIND_REPLY, B_ACK, 9'd0, 8'h00, nb);
    send_item(KIND_DATA, 8'h00, 9'd0, 8'h00, nb);
    send_item(KIND_ABORT, 8'h00, 9'd0, 8'h00, nb);
    send_item(KIND_START, 8'h00, 9'd0, 8'h00, nb);
    send_item(KIND_REPLY, B_NACK, 9'd0, 8'h00, nb);
    send_item(KIND_REPLY, B_NACK, 9'd0, 8'h00, nb);
    send_item(KIND_START, 8'h00, 9'd0, 8'h00, nb);
    send_item(KIND_REPLY, 8'hFF, 9'd0, 8'h00, nb);
    wait_drain();

    run_phase(32'h0000_0000, 3'd7, 22);
    long_hold_req = 1'b1;
    run_phase(32'hFFFF_FFFC, 3'd3, 22);
    run_phase($urandom, 3'($urandom_range(0, 7)), 22);
    calm = 1'b1;
    run_phase($urandom, 3'($urandom_range(0, 7)), 22);

    if (sb.faults == 0 && sb.pending_beats.size() == 0) begin
      $display("uart_bootloader_flash_programmer_tb: done, clean");
    end else begin
      $display("uart_bootloader_flash_programmer_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ubfp_pkg.sv
rtl/ubfp_step.sv
rtl/uart_bootloader_flash_programmer.sv
tb/uart_bootloader_flash_programmer_tb.sv
